// ===== sv/lds_pkg.sv =====
// ----------------------------------------------------------------------------
// lds_pkg
// Shared types and codes for the linear Diophantine solver.
// ----------------------------------------------------------------------------
package lds_pkg;

   // result status codes
   localparam logic [1:0] ST_SOLVED  = 2'd0;
   localparam logic [1:0] ST_NO_SOL  = 2'd1;
   localparam logic [1:0] ST_ZERO    = 2'd2;

   // sequencer states, one-hot
   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_LOOP  = 12'b0000_0000_0010,
      S_EDIV  = 12'b0000_0000_0100,
      S_UPD_S = 12'b0000_0000_1000,
      S_UPD_T = 12'b0000_0001_0000,
      S_CHECK = 12'b0000_0010_0000,
      S_CDIV  = 12'b0000_0100_0000,
      S_BDIV  = 12'b0000_1000_0000,
      S_ADIV  = 12'b0001_0000_0000,
      S_XMUL  = 12'b0010_0000_0000,
      S_YMUL  = 12'b0100_0000_0000,
      S_DONE  = 12'b1000_0000_0000
   } state_type;

endpackage

// ===== sv/linear_diophantine_solver.sv =====
// ----------------------------------------------------------------------------
// linear_diophantine_solver
// Solves a*x + b*y = c by the extended Euclidean algorithm (truncating
// division), giving gcd, Bezout pair, a particular solution and the steps.
// ----------------------------------------------------------------------------
// Each Euclid round runs a restoring divide (one quotient bit per cycle)
// and then two multiply-subtract updates; when a solution exists, the finish
// adds three more divides and two multiplies.
// Throughput: one word at a time; req_ready is high only while idle.
// Reset: synchronous, active high; returns the sequencer to idle, no result.
module linear_diophantine_solver import lds_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_coef_a,
   input  logic [31:0] req_coef_b,
   input  logic [31:0] req_rhs_c,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_gcd_value,
   output logic [31:0] rsp_bezout_s,
   output logic [31:0] rsp_bezout_t,
   output logic [63:0] rsp_x_base,
   output logic [63:0] rsp_y_base,
   output logic [31:0] rsp_x_step,
   output logic [31:0] rsp_y_step
);

   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(W + 1);

   state_type state_ff, state_in;

   logic signed [W-1:0] a0_ff, a0_in, b0_ff, b0_in, c_ff, c_in;
   logic signed [W-1:0] a_ff, a_in, b_ff, b_in, q_ff, q_in;
   logic signed [W-1:0] s1_ff, s1_in, s2_ff, s2_in, t1_ff, t1_in, t2_ff, t2_in;
   logic signed [W:0]   m_ff, m_in;
   logic [1:0]          status_ff, status_in;
   logic signed [63:0]  xb_ff, xb_in, yb_ff, yb_in;
   logic signed [W-1:0] xs_ff, xs_in, ys_ff, ys_in;

   // shared divider
   logic [W-1:0]  quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic          nneg_ff, nneg_in, qneg_ff, qneg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          div_go, div_busy, div_done;
   logic [W-1:0]  div_num, div_den;
   logic [W:0]    div_sh;
   logic          div_ge;
   logic signed [W-1:0] div_q, div_r;
   logic signed [W:0]   div_qx;

   // shared multiplier
   logic signed [W:0]       mul_a, mul_b;
   logic signed [2*W+1:0]   mul_prod;

   assign div_busy = (state_ff == S_EDIV) || (state_ff == S_CDIV) ||
                     (state_ff == S_BDIV) || (state_ff == S_ADIV);
   assign div_done = div_busy && (cnt_ff == CW'(W));

   // one restoring step
   assign div_sh = {rem_ff, quo_ff[W-1]};
   assign div_ge = div_sh >= {1'b0, dvs_ff};

   // signed results from magnitudes
   assign div_q  = qneg_ff ? -$signed(quo_ff) : $signed(quo_ff);
   assign div_qx = qneg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign div_r  = nneg_ff ? -$signed(rem_ff) : $signed(rem_ff);

   assign mul_prod = mul_a * mul_b;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      nneg_in = nneg_ff;
      qneg_in = qneg_ff;
      cnt_in  = cnt_ff;
      if (div_go) begin
         nneg_in = div_num[W-1];
         qneg_in = div_num[W-1] ^ div_den[W-1];
         quo_in  = div_num[W-1] ? (~div_num + 1'b1) : div_num;
         dvs_in  = div_den[W-1] ? (~div_den + 1'b1) : div_den;
         rem_in  = '0;
         cnt_in  = '0;
      end else if (div_busy && !div_done) begin
         rem_in = div_ge ? W'(div_sh - {1'b0, dvs_ff}) : div_sh[W-1:0];
         quo_in = {quo_ff[W-2:0], div_ge};
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      a0_in = a0_ff;  b0_in = b0_ff;  c_in = c_ff;
      a_in  = a_ff;   b_in  = b_ff;   q_in = q_ff;
      s1_in = s1_ff;  s2_in = s2_ff;  t1_in = t1_ff;  t2_in = t2_ff;
      m_in  = m_ff;   status_in = status_ff;
      xb_in = xb_ff;  yb_in = yb_ff;  xs_in = xs_ff;  ys_in = ys_ff;
      div_go  = 1'b0;
      div_num = '0;
      div_den = '0;
      mul_a   = '0;
      mul_b   = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               a0_in = req_coef_a[W-1:0];
               b0_in = req_coef_b[W-1:0];
               c_in  = req_rhs_c[W-1:0];
               a_in  = req_coef_a[W-1:0];
               b_in  = req_coef_b[W-1:0];
               s1_in = W'(1);  s2_in = '0;
               t1_in = '0;     t2_in = W'(1);
               status_in = ST_SOLVED;
               xb_in = '0;  yb_in = '0;  xs_in = '0;  ys_in = '0;
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            if (b_ff != '0) begin
               div_go   = 1'b1;
               div_num  = a_ff;
               div_den  = b_ff;
               state_in = S_EDIV;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_EDIV: begin
            if (div_done) begin
               q_in = div_q;
               a_in = b_ff;
               b_in = div_r;
               state_in = S_UPD_S;
            end
         end
         S_UPD_S: begin
            mul_a = (W+1)'(s2_ff);
            mul_b = (W+1)'(q_ff);
            s1_in = s2_ff;
            s2_in = s1_ff - mul_prod[W-1:0];
            state_in = S_UPD_T;
         end
         S_UPD_T: begin
            mul_a = (W+1)'(t2_ff);
            mul_b = (W+1)'(q_ff);
            t1_in = t2_ff;
            t2_in = t1_ff - mul_prod[W-1:0];
            state_in = S_LOOP;
         end
         S_CHECK: begin
            if (a_ff == '0) begin
               status_in = ST_ZERO;
               state_in  = S_DONE;
            end else begin
               div_go   = 1'b1;
               div_num  = c_ff;
               div_den  = a_ff;
               state_in = S_CDIV;
            end
         end
         S_CDIV: begin
            if (div_done) begin
               if (rem_ff != '0) begin
                  status_in = ST_NO_SOL;
                  state_in  = S_DONE;
               end else begin
                  m_in     = div_qx;
                  div_go   = 1'b1;
                  div_num  = b0_ff;
                  div_den  = a_ff;
                  state_in = S_BDIV;
               end
            end
         end
         S_BDIV: begin
            if (div_done) begin
               xs_in    = div_q;
               div_go   = 1'b1;
               div_num  = a0_ff;
               div_den  = a_ff;
               state_in = S_ADIV;
            end
         end
         S_ADIV: begin
            if (div_done) begin
               ys_in    = div_q;
               state_in = S_XMUL;
            end
         end
         S_XMUL: begin
            mul_a = (W+1)'(s1_ff);
            mul_b = m_ff;
            xb_in = 64'(mul_prod);
            state_in = S_YMUL;
         end
         S_YMUL: begin
            mul_a = (W+1)'(t1_ff);
            mul_b = m_ff;
            yb_in = 64'(mul_prod);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      a0_ff <= a0_in;  b0_ff <= b0_in;  c_ff <= c_in;
      a_ff  <= a_in;   b_ff  <= b_in;   q_ff <= q_in;
      s1_ff <= s1_in;  s2_ff <= s2_in;  t1_ff <= t1_in;  t2_ff <= t2_in;
      m_ff  <= m_in;   status_ff <= status_in;
      xb_ff <= xb_in;  yb_ff <= yb_in;  xs_ff <= xs_in;  ys_ff <= ys_in;
      quo_ff <= quo_in;  rem_ff <= rem_in;  dvs_ff <= dvs_in;
      nneg_ff <= nneg_in;  qneg_ff <= qneg_in;  cnt_ff <= cnt_in;
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = (state_ff == S_DONE);
   assign rsp_status    = status_ff;
   assign rsp_gcd_value = 32'(a_ff);
   assign rsp_bezout_s  = 32'(s1_ff);
   assign rsp_bezout_t  = 32'(t1_ff);
   assign rsp_x_base    = xb_ff;
   assign rsp_y_base    = yb_ff;
   assign rsp_x_step    = 32'(xs_ff);
   assign rsp_y_step    = 32'(ys_ff);

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("solver took a word while busy");
   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_ZERO |-> rsp_gcd_value != '0)
      else $error("zero gcd without zero status");
   a_zero_case: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ZERO |-> rsp_bezout_s == 32'd1 &&
      rsp_x_base == '0 && rsp_y_base == '0)
      else $error("bad result for both coefficients zero");
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      div_busy && !div_go |-> rem_ff < dvs_ff)
      else $error("divider remainder out of range");
`endif

endmodule
